[src/encoded_word_subject_encoder_defines.svh]
// ============================================================================
// Assertion macros for the encoded-word Subject encoder
// Shared concurrent-assertion forms, clocked on i_clk, quiet during reset.
// ============================================================================
`ifndef ENCODED_WORD_SUBJECT_ENCODER_DEFINES_SVH
`define ENCODED_WORD_SUBJECT_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define EWSE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EWSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ewse_pkg.sv]
// ============================================================================
// ewse_pkg
// Types, constants and character tables of the encoded-word Subject encoder.
// ============================================================================
package ewse_pkg;

    localparam int CHUNK_LIMIT_DEF = 42;
    localparam int IDX_W           = 5;

    localparam int HEAD_FIRST_LEN = 19;
    localparam int HEAD_NEXT_LEN  = 13;
    localparam int TAIL_LEN       = 2;

    localparam logic [8*HEAD_FIRST_LEN-1:0] HEAD_FIRST_STR = "Subject: =?UTF-8?B?";
    localparam logic [8*HEAD_NEXT_LEN-1:0]  HEAD_NEXT_STR  = {8'h0D, 8'h0A, " =?UTF-8?B?"};

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_B64,
        ST_TAIL,
        ST_WRITE
    } t_state;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_B64,
        PH_TAIL
    } t_phase;

    // controller -> datapath
    typedef struct packed {
        logic   take;
        logic   advance;
        t_phase phase;
        logic   write_b;
        logic   use_cut;
        logic   last_word;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic fin;
        logic head_last;
        logic b64_last;
        logic tail_last;
    } t_stat;

    // datapath -> packer
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       done;
        logic [7:0] data;
    } t_chr;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'({2'b00, v}) + 8'h41;
        end else if (v < 6'd52) begin
            c = 8'({2'b00, v}) + 8'h47;
        end else if (v < 6'd62) begin
            c = 8'({2'b00, v}) - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic logic [7:0] head_char(input logic next_word,
                                             input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (next_word) begin
            if (int'(idx) < HEAD_NEXT_LEN) begin
                c = HEAD_NEXT_STR[8*(HEAD_NEXT_LEN-1-int'(idx)) +: 8];
            end
        end else begin
            if (int'(idx) < HEAD_FIRST_LEN) begin
                c = HEAD_FIRST_STR[8*(HEAD_FIRST_LEN-1-int'(idx)) +: 8];
            end
        end
        return c;
    endfunction

endpackage

[src/ewse_ram.sv]
// ============================================================================
// ewse_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ewse_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 42,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/ewse_pack.sv]
// ============================================================================
// ewse_pack
// Packs the character stream into groups of up to four and holds the result.
// ============================================================================
module ewse_pack (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ewse_pkg::t_chr i_chr,
    input  logic          i_stall,
    output logic          o_room,
    output logic          o_valid,
    output logic [7:0]    o_char_a,
    output logic [7:0]    o_char_b,
    output logic [7:0]    o_char_c,
    output logic [7:0]    o_char_d,
    output logic [2:0]    o_char_count,
    output logic          o_run_end,
    output logic          o_header_done
);

    import ewse_pkg::*;

    logic [7:0] r_acc [3];
    logic [1:0] r_slot;
    logic       r_valid;
    logic [7:0] r_grp [4];
    logic [2:0] r_count;
    logic       r_run_end;
    logic       r_done;

    logic       flush;
    logic [7:0] grp [4];

    assign o_room = !r_valid || !i_stall;
    assign flush  = i_chr.valid && (r_slot == 2'd3 || i_chr.last);

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            if (p < int'(r_slot)) begin
                grp[p] = (p < 3) ? r_acc[p[1:0] == 2'd3 ? 2'd0 : p[1:0]] : 8'h00;
            end else if (p == int'(r_slot)) begin
                grp[p] = i_chr.data;
            end else begin
                grp[p] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (flush) begin
                r_slot  <= 2'd0;
                r_valid <= 1'b1;
            end else begin
                if (i_chr.valid) begin
                    r_slot <= r_slot + 2'd1;
                end
                if (r_valid && !i_stall) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_chr.valid && !flush) begin
            r_acc[r_slot] <= i_chr.data;
        end
        if (flush) begin
            r_grp     <= grp;
            r_count   <= {1'b0, r_slot} + 3'd1;
            r_run_end <= i_chr.last;
            r_done    <= i_chr.done;
        end
    end

    assign o_valid       = r_valid;
    assign o_char_a      = r_grp[0];
    assign o_char_b      = r_grp[1];
    assign o_char_c      = r_grp[2];
    assign o_char_d      = r_grp[3];
    assign o_char_count  = r_count;
    assign o_run_end     = r_run_end;
    assign o_header_done = r_done;

endmodule

[src/ewse_ctrl.sv]
// ============================================================================
// ewse_ctrl
// Sequencer: accepts bytes and steps through header, base64 and tail phases.
// ============================================================================
module ewse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_final_byte,
    input  logic            i_room,
    input  ewse_pkg::t_stat i_stat,
    output ewse_pkg::t_cmd  o_cmd,
    output logic            o_stall
);

    import ewse_pkg::*;

    t_state r_state, n_state;
    logic   r_cut_word, n_cut_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cut_word <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cut_word <= n_cut_word;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_cut_word       = r_cut_word;
        o_cmd            = '0;
        o_cmd.phase      = PH_HEAD;
        o_cmd.use_cut    = r_cut_word;
        // a cut word closes the run unless the final word follows it
        o_cmd.last_word  = !r_cut_word || !i_stat.fin;
        o_stall          = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.full) begin
                        n_cut_word = 1'b1;
                        n_state    = ST_HEAD;
                    end else if (i_final_byte) begin
                        n_cut_word = 1'b0;
                        n_state    = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                o_cmd.phase   = PH_HEAD;
                o_cmd.advance = i_room;
                if (i_room && i_stat.head_last) begin
                    n_state = ST_B64;
                end
            end
            ST_B64: begin
                o_cmd.phase   = PH_B64;
                o_cmd.advance = i_room;
                if (i_room && i_stat.b64_last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                o_cmd.phase   = PH_TAIL;
                o_cmd.advance = i_room;
                if (i_room && i_stat.tail_last) begin
                    n_state = r_cut_word ? ST_WRITE : ST_IDLE;
                end
            end
            ST_WRITE: begin
                o_cmd.write_b = 1'b1;
                if (i_stat.fin) begin
                    n_cut_word = 1'b0;
                    n_state    = ST_HEAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[src/ewse_dp.sv]
// ============================================================================
// ewse_dp
// Datapath: chunk ring in RAM, cut search, counters and character generator.
// ============================================================================
module ewse_dp #(
    parameter int CHUNK_LIMIT = ewse_pkg::CHUNK_LIMIT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_data_byte,
    input  logic            i_final_byte,
    input  ewse_pkg::t_cmd  i_cmd,
    output ewse_pkg::t_stat o_stat,
    output ewse_pkg::t_chr  o_chr
);

    import ewse_pkg::*;

    localparam int AW = $clog2(CHUNK_LIMIT);
    localparam int FW = $clog2(CHUNK_LIMIT + 1);
    localparam logic [FW-1:0] LIMIT = FW'(CHUNK_LIMIT);

    // map an offset within the current chunk onto the ring
    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] b_in,
                                                input logic [FW:0]   off);
        logic [FW:0] sum;
        sum = {{(FW+1-AW){1'b0}}, b_in} + off;
        if (sum >= (FW+1)'(CHUNK_LIMIT)) begin
            sum = sum - (FW+1)'(CHUNK_LIMIT);
        end
        return sum[AW-1:0];
    endfunction

    logic [7:0]       r_byte;
    logic             r_fin;
    logic [2:0]       r_flags;
    logic [FW-1:0]    r_cut;
    logic [FW-1:0]    r_fill;
    logic [AW-1:0]    r_base;
    logic             r_words;
    logic [IDX_W-1:0] r_idx;
    logic [FW-1:0]    r_j;
    logic [1:0]       r_q;
    logic [7:0]       r_prev;

    logic             full;
    logic             byte_cont;
    logic [FW-1:0]    cut_calc;
    logic [FW:0]      len;
    logic [FW:0]      j1, j2, j3;
    logic             v1, v2;
    logic             head_last, b64_last, tail_last;
    logic [FW:0]      rd_off;
    logic             rd_en;
    logic             re;
    logic [AW-1:0]    raddr;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [7:0]       wdata;
    logic [7:0]       rd;
    logic [5:0]       sextet;
    logic [7:0]       b64_out;
    logic [7:0]       chr;

    assign full      = (r_fill == LIMIT);
    assign byte_cont = (i_data_byte[7:6] == 2'b10);

    // back off toward the last lead byte, at most three steps
    always_comb begin
        if (!byte_cont) begin
            cut_calc = LIMIT;
        end else if (!r_flags[0]) begin
            cut_calc = LIMIT - FW'(1);
        end else if (!r_flags[1]) begin
            cut_calc = LIMIT - FW'(2);
        end else if (!r_flags[2]) begin
            cut_calc = LIMIT - FW'(3);
        end else begin
            cut_calc = LIMIT;
        end
    end

    assign len = {1'b0, (i_cmd.use_cut ? r_cut : r_fill)};
    assign j1  = {1'b0, r_j} + (FW+1)'(1);
    assign j2  = {1'b0, r_j} + (FW+1)'(2);
    assign j3  = {1'b0, r_j} + (FW+1)'(3);
    assign v1  = (j1 < len);
    assign v2  = (j2 < len);

    assign head_last = r_words ? (r_idx == IDX_W'(HEAD_NEXT_LEN - 1))
                               : (r_idx == IDX_W'(HEAD_FIRST_LEN - 1));
    assign b64_last  = (r_q == 2'd3) && (j3 >= len);
    assign tail_last = (r_idx == IDX_W'(TAIL_LEN - 1));

    // prefetch the byte that the next character needs
    always_comb begin
        rd_off = '0;
        rd_en  = 1'b0;
        case (i_cmd.phase)
            PH_HEAD: begin
                rd_en = 1'b1;
            end
            PH_B64: begin
                case (r_q)
                    2'd0: begin
                        rd_off = j1;
                        rd_en  = 1'b1;
                    end
                    2'd1: begin
                        rd_off = j2;
                        rd_en  = 1'b1;
                    end
                    2'd3: begin
                        rd_off = j3;
                        rd_en  = 1'b1;
                    end
                    default: begin
                        rd_en = 1'b0;
                    end
                endcase
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign re    = i_cmd.advance && rd_en && (rd_off < len);
    assign raddr = wrap_addr(r_base, rd_off);

    assign we    = (i_cmd.take && !full) || i_cmd.write_b;
    assign waddr = i_cmd.write_b ? r_base : wrap_addr(r_base, {1'b0, r_fill});
    assign wdata = i_cmd.write_b ? r_byte : i_data_byte;

    ewse_ram #(
        .WIDTH (8),
        .DEPTH (CHUNK_LIMIT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    always_comb begin
        case (r_q)
            2'd0:    sextet = rd[7:2];
            2'd1:    sextet = {r_prev[1:0], (v1 ? rd[7:4] : 4'h0)};
            2'd2:    sextet = {r_prev[3:0], (v2 ? rd[7:6] : 2'b00)};
            default: sextet = rd[5:0];
        endcase
        if ((r_q == 2'd2 && !v1) || (r_q == 2'd3 && !v2)) begin
            b64_out = CH_EQ;
        end else begin
            b64_out = b64_char(sextet);
        end
    end

    always_comb begin
        case (i_cmd.phase)
            PH_HEAD: chr = head_char(r_words, r_idx);
            PH_B64:  chr = b64_out;
            PH_TAIL: chr = (r_idx == '0) ? CH_QMARK : CH_EQ;
            default: chr = 8'h00;
        endcase
    end

    assign o_chr.valid = i_cmd.advance;
    assign o_chr.data  = chr;
    assign o_chr.last  = (i_cmd.phase == PH_TAIL) && tail_last && i_cmd.last_word;
    assign o_chr.done  = o_chr.last && r_fin;

    assign o_stat.full      = full;
    assign o_stat.fin       = r_fin;
    assign o_stat.head_last = head_last;
    assign o_stat.b64_last  = b64_last;
    assign o_stat.tail_last = tail_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin   <= 1'b0;
            r_fill  <= '0;
            r_base  <= '0;
            r_words <= 1'b0;
            r_idx   <= '0;
            r_j     <= '0;
            r_q     <= 2'd0;
        end else begin
            if (i_cmd.take) begin
                r_fin <= i_final_byte;
                if (!full) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
            if (i_cmd.write_b) begin
                // keep the tail of the cut chunk in place, new byte follows it
                r_base <= wrap_addr(r_base, {1'b0, r_cut});
                r_fill <= LIMIT - r_cut + FW'(1);
            end
            if (i_cmd.advance) begin
                case (i_cmd.phase)
                    PH_HEAD: begin
                        r_idx <= head_last ? '0 : r_idx + IDX_W'(1);
                    end
                    PH_B64: begin
                        r_q <= r_q + 2'd1;
                        if (r_q == 2'd3) begin
                            r_j <= b64_last ? '0 : r_j + FW'(3);
                        end
                    end
                    PH_TAIL: begin
                        if (tail_last) begin
                            r_idx <= '0;
                            if (i_cmd.last_word && r_fin) begin
                                r_fill  <= '0;
                                r_words <= 1'b0;
                            end else begin
                                r_words <= 1'b1;
                            end
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                    default: begin
                        r_idx <= r_idx;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_byte  <= i_data_byte;
            r_flags <= {r_flags[1:0], byte_cont};
            if (full) begin
                r_cut <= cut_calc;
            end
        end
        if (i_cmd.advance && i_cmd.phase == PH_B64 && (r_q == 2'd0 || r_q == 2'd1)) begin
            r_prev <= rd;
        end
    end

endmodule

[src/encoded_word_subject_encoder.sv]
// ============================================================================
// encoded_word_subject_encoder
// Builds a Subject header of base64 encoded words from file-name UTF-8 bytes.
// ============================================================================
// Bytes arrive one per transaction and collect in a ring of CHUNK_LIMIT bytes
// held in a single RAM. A byte that completes nothing is taken with no stall.
// The byte that arrives after a full chunk decides the cut (backing off to
// the last lead byte, at most three steps) and the word is sent; a byte that
// carries final_byte sends the last word and ends the header. A word is
// produced one character per cycle while the output has room: 19 header
// characters for the first word ("Subject: =?UTF-8?B?") or 13 for later
// ones (CR LF space, "=?UTF-8?B?"), then 4*ceil(n/3) base64 characters for
// n bytes, then "?=". After a cut a write state puts the new byte into the
// ring. The generator's single RAM read port fetches one byte ahead of the
// character that needs it. Characters are packed into groups of up to four;
// a short group appears only at the end of a run. Output stall holds the
// generator; no input is taken while a word is being sent, but the last
// group of a run may still wait at the output while the next byte is taken.
// The store needs no clearing pass after reset.
// ============================================================================
`include "encoded_word_subject_encoder_defines.svh"

module encoded_word_subject_encoder #(
    parameter int CHUNK_LIMIT = ewse_pkg::CHUNK_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    // character group channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_a,
    output logic [7:0] o_char_b,
    output logic [7:0] o_char_c,
    output logic [7:0] o_char_d,
    output logic [2:0] o_char_count,
    output logic       o_run_end,
    output logic       o_header_done
);

    import ewse_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    t_chr  w_chr;
    logic  w_room;

    // sequence the phases of each word
    ewse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_final_byte (i_final_byte),
        .i_room       (w_room),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_stall      (o_stall)
    );

    // hold the chunk, pick the cut, generate characters
    ewse_dp #(
        .CHUNK_LIMIT (CHUNK_LIMIT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_chr        (w_chr)
    );

    // pack characters into groups and drive the output register
    ewse_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_chr         (w_chr),
        .i_stall       (i_stall),
        .o_room        (w_room),
        .o_valid       (o_valid),
        .o_char_a      (o_char_a),
        .o_char_b      (o_char_b),
        .o_char_c      (o_char_c),
        .o_char_d      (o_char_d),
        .o_char_count  (o_char_count),
        .o_run_end     (o_run_end),
        .o_header_done (o_header_done)
    );

    // a short group only closes a run
    `EWSE_ASSERT_IMPL(a_short_group_ends_run, o_valid && (o_char_count != 3'd4), o_run_end, "short group before end of run")

    // the header can only complete on the last group of a run
    `EWSE_ASSERT_IMPL(a_done_on_run_end, o_valid && o_header_done, o_run_end, "header done off run end")

    // a cut or a final byte always starts a word
    `EWSE_ASSERT_NEXT(a_word_starts, i_valid && !o_stall && (i_final_byte || w_stat.full), o_stall, "word not started")

endmodule

[tb/testbench.sv]
// ============================================================================
// Subject header encoder testbench
// Streams file-name bytes into the encoder, rebuilds the expected Subject
// header text in a local model and checks every character group, with random
// gaps and stalls on both sides and one long output hold-off.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BYTES   = ewse_pkg::CHUNK_LIMIT_DEF;
    localparam int NAME_ITEMS   = 220;
    localparam int CUT_CASES    = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int SHOW_MAX     = 30;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [8*64-1:0] B64_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Where the cut of a full word falls, judged from the byte that arrives
    // after the word is full and the three bytes held just before it.
    typedef enum int {
        CUT_AT_LIMIT,
        CUT_BACK_ONE,
        CUT_BACK_TWO,
        CUT_BACK_THREE,
        CUT_NO_LEAD
    } t_cut_case;

    typedef enum int {
        NAME_BOUNDARY,
        NAME_UTF8,
        NAME_NOISE
    } t_name_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_name_byte;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic [2:0] count;
        logic       run_end;
        logic       done;
    } t_char_group;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_char_a;
    logic [7:0] o_char_b;
    logic [7:0] o_char_c;
    logic [7:0] o_char_d;
    logic [2:0] o_char_count;
    logic       o_run_end;
    logic       o_header_done;

    encoded_word_subject_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_char_a     (o_char_a),
        .o_char_b     (o_char_b),
        .o_char_c     (o_char_c),
        .o_char_d     (o_char_d),
        .o_char_count (o_char_count),
        .o_run_end    (o_run_end),
        .o_header_done(o_header_done)
    );

    // ------------------------------------------------------------------------
    // Header model state: bytes of the word being collected, how many are
    // held, and whether a word of the current header already went out.
    // ------------------------------------------------------------------------
    logic [7:0]  word_buf [WORD_BYTES];
    int          held_bytes = 0;
    bit          word_sent  = 1'b0;
    logic [7:0]  header_text[$];
    t_char_group expected_groups[$];

    // Stimulus and bookkeeping
    t_name_byte send_q[$];
    logic [7:0] name_buf[$];
    int         total_bytes = 0;
    int         bytes_taken = 0;
    int         error_cnt   = 0;
    bit         in_fire     = 1'b0;
    bit         out_fire    = 1'b0;

    // Sender and receiver pacing, each owned by its own process
    int tx_gap    = 0;
    bit tx_quiet  = 1'b0;
    int rx_wait   = 0;
    int rx_hold   = 0;
    bit rx_quiet  = 1'b0;
    bit hold_used = 1'b0;

    function automatic bit is_cont(input logic [7:0] v);
        return (v & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic logic [7:0] b64_digit(input logic [5:0] v);
        return B64_SET[8*(63 - int'(v)) +: 8];
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            header_text.push_back(8'(s[i]));
        end
    endfunction

    // Append one encoded word made of the first n held bytes.
    function automatic void push_word(input int n);
        logic [23:0] v;
        if (word_sent) begin
            header_text.push_back(CH_CR);
            header_text.push_back(CH_LF);
            push_text(" ");
        end else begin
            push_text("Subject: ");
        end
        push_text("=?UTF-8?B?");
        for (int i = 0; i < n; i += 3) begin
            v = {word_buf[i],
                 (i + 1 < n) ? word_buf[i + 1] : 8'h00,
                 (i + 2 < n) ? word_buf[i + 2] : 8'h00};
            header_text.push_back(b64_digit(v[23:18]));
            header_text.push_back(b64_digit(v[17:12]));
            header_text.push_back((i + 1 < n) ? b64_digit(v[11:6]) : ewse_pkg::CH_EQ);
            header_text.push_back((i + 2 < n) ? b64_digit(v[5:0]) : ewse_pkg::CH_EQ);
        end
        push_text("?=");
        word_sent = 1'b1;
    endfunction

    // Advance the header model by one accepted byte and queue the groups
    // of characters it causes.
    function automatic void predict_groups(input logic [7:0] b, input logic fin);
        int          cut;
        int          keep;
        int          cnt;
        t_char_group g;
        header_text.delete();
        if (held_bytes >= WORD_BYTES) begin
            // The byte after a full word decides the cut: back off toward
            // the last lead byte, but never more than three steps.
            cut = WORD_BYTES;
            if (is_cont(b)) begin
                if (!is_cont(word_buf[WORD_BYTES - 1])) begin
                    cut = WORD_BYTES - 1;
                end else if (!is_cont(word_buf[WORD_BYTES - 2])) begin
                    cut = WORD_BYTES - 2;
                end else if (!is_cont(word_buf[WORD_BYTES - 3])) begin
                    cut = WORD_BYTES - 3;
                end
            end
            push_word(cut);
            keep = WORD_BYTES - cut;
            for (int k = 0; k < keep; k++) begin
                word_buf[k] = word_buf[cut + k];
            end
            word_buf[keep] = b;
            held_bytes = keep + 1;
        end else begin
            word_buf[held_bytes] = b;
            held_bytes++;
        end
        if (fin) begin
            push_word(held_bytes);
            held_bytes = 0;
            word_sent  = 1'b0;
        end
        for (int base = 0; base < header_text.size(); base += 4) begin
            cnt = header_text.size() - base;
            if (cnt > 4) begin
                cnt = 4;
            end
            g         = '0;
            g.a       = header_text[base];
            g.b       = (cnt > 1) ? header_text[base + 1] : 8'h00;
            g.c       = (cnt > 2) ? header_text[base + 2] : 8'h00;
            g.d       = (cnt > 3) ? header_text[base + 3] : 8'h00;
            g.count   = 3'(cnt);
            g.run_end = (base + 4 >= header_text.size());
            g.done    = g.run_end && fin;
            expected_groups.push_back(g);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Name builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] cont_byte();
        return CONT_TAG | 8'($urandom_range(0, 63));
    endfunction

    // Any byte that is not a continuation byte: ASCII or a lead byte.
    function automatic logic [7:0] lead_byte();
        int v;
        v = $urandom_range(0, 191);
        if (v >= 128) begin
            v += 64;
        end
        return 8'(v);
    endfunction

    // Move the collected name into the send queue, final flag on its last byte.
    function automatic void flush_name();
        t_name_byte nb;
        for (int k = 0; k < name_buf.size(); k++) begin
            nb.data = name_buf[k];
            nb.fin  = (k == name_buf.size() - 1);
            send_q.push_back(nb);
        end
        name_buf.delete();
    endfunction

    // Fixed name, bytes packed first-byte-first from the top.
    function automatic void add_fixed_name(input logic [63:0] bytes, input int n);
        for (int k = 0; k < n; k++) begin
            name_buf.push_back(bytes[63 - 8*k -: 8]);
        end
        flush_name();
    endfunction

    function automatic void add_utf8_char();
        int len;
        len = $urandom_range(1, 4);
        case (len)
            1: begin
                name_buf.push_back(8'($urandom_range(0, 127)));
            end
            2: begin
                name_buf.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            end
            3: begin
                name_buf.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            end
            default: begin
                name_buf.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            end
        endcase
        for (int k = 1; k < len; k++) begin
            name_buf.push_back(cont_byte());
        end
    endfunction

    // Fill a word exactly, then steer the three last held bytes and the next
    // one so that the cut lands where the case asks; add a short tail.
    function automatic void add_boundary_name(input t_cut_case cc);
        logic [7:0] p39;
        logic [7:0] p40;
        logic [7:0] p41;
        logic [7:0] p42;
        for (int k = 0; k < WORD_BYTES - 3; k++) begin
            name_buf.push_back(any_byte());
        end
        p39 = any_byte();
        p40 = any_byte();
        p41 = any_byte();
        p42 = cont_byte();
        case (cc)
            CUT_AT_LIMIT: begin
                p42 = lead_byte();
            end
            CUT_BACK_ONE: begin
                p41 = lead_byte();
            end
            CUT_BACK_TWO: begin
                p41 = cont_byte();
                p40 = lead_byte();
            end
            CUT_BACK_THREE: begin
                p41 = cont_byte();
                p40 = cont_byte();
                p39 = lead_byte();
            end
            default: begin
                p41 = cont_byte();
                p40 = cont_byte();
                p39 = cont_byte();
            end
        endcase
        name_buf.push_back(p39);
        name_buf.push_back(p40);
        name_buf.push_back(p41);
        name_buf.push_back(p42);
        repeat ($urandom_range(0, 4)) begin
            name_buf.push_back(any_byte());
        end
        flush_name();
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------------
    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    initial begin : reset_gen
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Abort a hung run; the limit is far above the slowest legal run.
    initial begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed names first, then one name per cut case, then
    // random names until enough bytes are queued. Then wait for the drain.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int         boundary_names;
        t_name_kind kind;
        int         pick;
        int         len;
        boundary_names = 0;

        // Short names: both extreme bytes alone, a leading continuation byte,
        // every base64 padding length, well-formed multibyte characters and
        // patterns that flip every data bit.
        add_fixed_name(64'h00_00000000000000, 1);
        add_fixed_name(64'hFF_00000000000000, 1);
        add_fixed_name(64'h80_7F_000000000000, 2);
        add_fixed_name(64'h41_42_43_0000000000, 3);
        add_fixed_name(64'hE2_82_AC_55_00000000, 4);
        add_fixed_name(64'hF0_9F_98_80_3F_000000, 5);
        add_fixed_name(64'hAA_55_0F_F0_33_CC_0000, 6);

        while (send_q.size() < NAME_ITEMS || boundary_names < CUT_CASES) begin
            pick = $urandom_range(0, 99);
            if (boundary_names < CUT_CASES) begin
                kind = NAME_BOUNDARY;
            end else if (pick < 60) begin
                kind = NAME_UTF8;
            end else begin
                kind = NAME_NOISE;
            end
            case (kind)
                NAME_BOUNDARY: begin
                    add_boundary_name(t_cut_case'(boundary_names % CUT_CASES));
                    boundary_names++;
                end
                NAME_UTF8: begin
                    // Mostly short names, sometimes long enough to cut.
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 70)
                                                      : $urandom_range(1, 20);
                    while (name_buf.size() < len) begin
                        add_utf8_char();
                    end
                    flush_name();
                end
                default: begin
                    repeat ($urandom_range(1, 30)) begin
                        name_buf.push_back(any_byte());
                    end
                    flush_name();
                end
            endcase
        end
        total_bytes = send_q.size();

        // Hold until every byte is taken and every group has come back.
        @(posedge i_rst_n);
        while (bytes_taken < total_bytes || expected_groups.size() != 0) begin
            @(posedge i_clk);
        end
        // Give stray groups a chance to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_cnt == 0 && expected_groups.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: present the next byte at the falling edge once the previous
    // transaction went through, after its drawn gap. Quiet stretches drop
    // the gaps for a while.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_name_byte nb;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (send_q.size() != 0) begin
                nb = send_q.pop_front();
                i_data_byte  <= nb.data;
                i_final_byte <= nb.fin;
                i_valid      <= 1'b1;
                if ($urandom_range(0, 31) == 0) begin
                    tx_quiet = !tx_quiet;
                end
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 3);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall for a drawn number of cycles after each transaction,
    // and once, after some bytes went in, hold off long enough that the
    // encoder backs up and stalls its byte input while the driver keeps
    // offering.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!hold_used && bytes_taken >= HOLD_AFTER) begin
                hold_used = 1'b1;
                rx_hold   = HOLD_CYCLES;
            end
            if (out_fire) begin
                if ($urandom_range(0, 31) == 0) begin
                    rx_quiet = !rx_quiet;
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 3);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge, check an output transaction against the
    // oldest expected group first, then feed an accepted byte to the model;
    // groups seen at this edge always belong to earlier bytes.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_char_group got;
        t_char_group want;
        if (!i_rst_n) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire  <= i_valid && !o_stall;
            out_fire <= o_valid && !i_stall;
            if (o_valid && !i_stall) begin
                got = {o_char_a, o_char_b, o_char_c, o_char_d,
                       o_char_count, o_run_end, o_header_done};
                if (expected_groups.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= SHOW_MAX) begin
                        $display("%0t: unexpected group, expected none, actual %h %h %h %h",
                                 $realtime, got.a, got.b, got.c, got.d,
                                 " count %0d end %b done %b",
                                 got.count, got.run_end, got.done);
                    end
                end else begin
                    want = expected_groups.pop_front();
                    if (got !== want) begin
                        error_cnt++;
                        if (error_cnt <= SHOW_MAX) begin
                            $display("%0t: group mismatch, expected %h %h %h %h",
                                     $realtime, want.a, want.b, want.c, want.d,
                                     " count %0d end %b done %b",
                                     want.count, want.run_end, want.done,
                                     ", actual %h %h %h %h count %0d end %b done %b",
                                     got.a, got.b, got.c, got.d,
                                     got.count, got.run_end, got.done);
                        end
                    end
                end
            end
            if (i_valid && !o_stall) begin
                predict_groups(i_data_byte, i_final_byte);
                bytes_taken++;
            end
        end
    end

endmodule

[filelist.f]
+incdir+src
src/ewse_pkg.sv
src/ewse_ram.sv
src/ewse_pack.sv
src/ewse_ctrl.sv
src/ewse_dp.sv
src/encoded_word_subject_encoder.sv
tb/testbench.sv
